// ===== design/msw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msw_pkg: shared types and constants of the model switch step
// payload structs, controller/datapath interface structs, fixed-point
// constants of the exponential and the reciprocal table of the term divide
// ----------------------------------------------------------------------------
package msw_pkg;

  localparam int MAX_MODELS = 16;
  localparam int MIN_MODELS = 2;
  localparam int RAND_BITS  = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int DELTA_W    = 24;
  localparam int STEP_W     = 4;
  localparam int QUOT_BITS  = 6;   // quotient bits of the ln2 range reduction
  localparam int EXP_TERMS  = 12;  // taylor terms after the constant one
  localparam int CMP_SHIFT  = 24 - RAND_BITS;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [36:0] XO_OFFSET = 37'd71449067328;  // 24 * ln2 in q32
  localparam logic [31:0] E_MAX     = 32'hFFFF_FFFF;
  localparam logic signed [DELTA_W-1:0] DELTA_HI = 24'sd1048576;  // 16.0
  localparam logic signed [DELTA_W-1:0] DELTA_LO = -24'sd393216;  // -6.0

  typedef struct packed {
    logic [RAND_BITS-1:0]      step_rand;
    logic [RAND_BITS-1:0]      accept_rand;
    logic signed [DELTA_W-1:0] action_delta;
  } in_t;

  typedef struct packed {
    logic             accepted;
    logic [IDX_W-1:0] proposed_model;
    logic [IDX_W-1:0] model_index;
  } out_t;

  typedef struct packed {
    logic              load;
    logic              red;
    logic              mul_term;
    logic              mul_recip;
    logic              fix;
    logic              exp_fin;
    logic              wb;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic out_free;
  } sts_t;

  // floor(2^32 / k), saturated for k of one; estimate is low by at most one
  function automatic logic [31:0] recip_q32(input logic [3:0] k);
    logic [31:0] r;
    unique case (k)
      4'd2:    r = 32'h8000_0000;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h4000_0000;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h2000_0000;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      4'd11:   r = 32'h1745_D174;
      4'd12:   r = 32'h1555_5555;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

// ===== design/msw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msw_ctrl: sequencer of the model switch step
// walks the range reduction, the taylor loop, the exponential finish and
// the write-back, issuing one command set per cycle to the datapath
// ----------------------------------------------------------------------------
module msw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  msw_pkg::sts_t sts_i,
  output msw_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RED  = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_FIX  = 7'b0010000,
    S_EXP  = 7'b0100000,
    S_WB   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [msw_pkg::STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    cmd_o.step = step_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = S_RED;
        end
      end
      S_RED: begin
        if (sts_i.bypass) begin
          state_d = S_EXP;
        end else begin
          cmd_o.red = 1'b1;
          if (step_q == msw_pkg::STEP_W'(msw_pkg::QUOT_BITS - 1)) begin
            step_d  = '0;
            state_d = S_MUL;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul_term = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.mul_recip = 1'b1;
        state_d         = S_FIX;
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        if (step_q == msw_pkg::STEP_W'(msw_pkg::EXP_TERMS - 1)) begin
          step_d  = '0;
          state_d = S_EXP;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_EXP: begin
        cmd_o.exp_fin = 1'b1;
        state_d       = S_WB;
      end
      S_WB: begin
        if (sts_i.out_free) begin
          cmd_o.wb = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  a_red_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RED) |-> (step_q < msw_pkg::STEP_W'(msw_pkg::QUOT_BITS)))
    else $error("reduction step out of range");

  a_term_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL || state_q == S_DIV || state_q == S_FIX) |->
    (step_q < msw_pkg::STEP_W'(msw_pkg::EXP_TERMS)))
    else $error("taylor term index out of range");

endmodule

// ===== design/msw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msw_dp: datapath of the model switch step
// proposal and ratio setup, ln2 range reduction, taylor series on one
// shared multiplier, scaling and the acceptance compare, output register
// ----------------------------------------------------------------------------
module msw_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  msw_pkg::cmd_t              cmd_i,
  output msw_pkg::sts_t              sts_o,
  input  msw_pkg::in_t               in_data_i,
  input  logic                       cfg_we_i,
  input  logic [msw_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output msw_pkg::out_t              out_data_o
);

  // control state
  logic [msw_pkg::CNT_W-1:0] cfg_q, cfg_d;
  logic [msw_pkg::IDX_W-1:0] cur_q, cur_d;
  logic                      out_valid_q, out_valid_d;

  // payload
  msw_pkg::out_t                 out_q, out_d;
  logic [msw_pkg::IDX_W-1:0]     j_q, j_d;
  logic [msw_pkg::CNT_W-1:0]     num_q, num_d, den_q, den_d;
  logic                          ok_q, ok_d, big_q, big_d, neg_q, neg_d;
  logic [msw_pkg::RAND_BITS-1:0] arand_q, arand_d;
  logic [36:0]                   rem_q, rem_d;
  logic [msw_pkg::QUOT_BITS-1:0] m_q, m_d;
  logic [32:0]                   term_q, term_d;
  logic [33:0]                   sum_q, sum_d;
  logic [64:0]                   prod_q, prod_d;
  logic [31:0]                   p_q, p_d;
  logic [31:0]                   e_q, e_d;

  // setup from the incoming transaction
  logic [msw_pkg::CNT_W-1:0]               n_eff, nm1, cur_x;
  logic [msw_pkg::RAND_BITS+msw_pkg::IDX_W-1:0] up_lhs;
  logic                                    up;
  logic signed [40:0]                      xo_full;

  always_comb begin
    if (cfg_q < msw_pkg::CNT_W'(msw_pkg::MIN_MODELS)) begin
      n_eff = msw_pkg::CNT_W'(msw_pkg::MIN_MODELS);
    end else if (cfg_q > msw_pkg::CNT_W'(msw_pkg::MAX_MODELS)) begin
      n_eff = msw_pkg::CNT_W'(msw_pkg::MAX_MODELS);
    end else begin
      n_eff = cfg_q;
    end
  end

  assign nm1    = n_eff - 1'b1;
  assign cur_x  = {1'b0, cur_q};
  assign up_lhs = in_data_i.step_rand * nm1[msw_pkg::IDX_W-1:0];
  assign up     = up_lhs >= {cur_q, {msw_pkg::RAND_BITS{1'b0}}};
  assign xo_full = $signed({4'b0, msw_pkg::XO_OFFSET})
                 - $signed({in_data_i.action_delta[msw_pkg::DELTA_W-1],
                            in_data_i.action_delta, 16'b0});

  // range reduction step: one quotient bit of x / ln2 per cycle
  logic [2:0]  red_bit;
  logic [36:0] trial;
  assign red_bit = 3'(msw_pkg::QUOT_BITS - 1) - cmd_i.step[2:0];
  assign trial   = {5'b0, msw_pkg::LN2_Q32} << red_bit;

  // shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [3:0]  k;
  assign k = cmd_i.step + 1'b1;

  always_comb begin
    if (cmd_i.mul_recip) begin
      mul_a = {1'b0, prod_q[63:32]};
      mul_b = msw_pkg::recip_q32(k);
    end else begin
      mul_a = term_q;
      mul_b = rem_q[31:0];
    end
  end

  // divide-by-k correction
  logic [31:0] q_est, q_fix;
  logic [35:0] qk, rdiff;
  assign q_est = prod_q[63:32];
  assign qk    = q_est * k;
  assign rdiff = {4'b0, p_q} - qk;
  assign q_fix = (rdiff >= {32'b0, k}) ? q_est + 1'b1 : q_est;

  // scale to q8.24
  logic [5:0]  sh_amt;
  logic [33:0] scaled;
  assign sh_amt = 6'd32 - m_q;
  assign scaled = sum_q >> sh_amt;

  // acceptance test on a common scale
  logic [msw_pkg::RAND_BITS+msw_pkg::CNT_W-1:0] a_prod;
  logic [36:0]                                  lhs, rhs;
  logic                                         acc;
  assign a_prod = arand_q * num_q;
  assign lhs    = 37'({a_prod, {msw_pkg::CMP_SHIFT{1'b0}}});
  assign rhs    = e_q * den_q;
  assign acc    = ok_q && (lhs <= rhs);

  always_comb begin
    cfg_d       = cfg_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    j_d = j_q;  num_d = num_q;  den_d = den_q;
    ok_d = ok_q;  big_d = big_q;  neg_d = neg_q;  arand_d = arand_q;
    rem_d = rem_q;  m_d = m_q;  term_d = term_q;  sum_d = sum_q;
    prod_d = prod_q;  p_d = p_q;  e_d = e_q;

    if (cfg_we_i) begin
      cfg_d = cfg_wdata_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load) begin
      j_d     = up ? cur_q + 1'b1 : cur_q - 1'b1;
      num_d   = up ? n_eff - 1'b1 - cur_x : cur_x;
      den_d   = up ? cur_x + 1'b1 : n_eff - cur_x;
      ok_d    = cur_x < n_eff;
      big_d   = in_data_i.action_delta > msw_pkg::DELTA_HI;
      neg_d   = in_data_i.action_delta < msw_pkg::DELTA_LO;
      arand_d = in_data_i.accept_rand;
      rem_d   = xo_full[36:0];
      m_d     = '0;
      term_d  = 33'h1_0000_0000;
      sum_d   = 34'h1_0000_0000;
    end
    if (cmd_i.red && (rem_q >= trial)) begin
      rem_d          = rem_q - trial;
      m_d[red_bit]   = 1'b1;
    end
    if (cmd_i.mul_term || cmd_i.mul_recip) begin
      prod_d = mul_a * mul_b;
    end
    if (cmd_i.mul_recip) begin
      p_d = prod_q[63:32];
    end
    if (cmd_i.fix) begin
      term_d = {1'b0, q_fix};
      sum_d  = sum_q + {2'b0, q_fix};
    end
    if (cmd_i.exp_fin) begin
      if (big_q) begin
        e_d = '0;
      end else if (neg_q || (|scaled[33:32])) begin
        e_d = msw_pkg::E_MAX;
      end else begin
        e_d = scaled[31:0];
      end
    end
    if (cmd_i.wb) begin
      out_valid_d          = 1'b1;
      out_d.accepted       = acc;
      out_d.proposed_model = j_q;
      out_d.model_index    = acc ? j_q : cur_q;
      cur_d                = acc ? j_q : cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= msw_pkg::CNT_W'(msw_pkg::MIN_MODELS);
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    j_q <= j_d;  num_q <= num_d;  den_q <= den_d;
    ok_q <= ok_d;  big_q <= big_d;  neg_q <= neg_d;  arand_q <= arand_d;
    rem_q <= rem_d;  m_q <= m_d;  term_q <= term_d;  sum_q <= sum_d;
    prod_q <= prod_d;  p_q <= p_d;  e_q <= e_d;
  end

  assign sts_o.bypass   = !ok_q || big_q || neg_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  a_wb_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wb |-> (!out_valid_q || out_ready_i))
    else $error("result written over an untaken transaction");

  a_index_only_at_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.wb |=> $stable(cur_q))
    else $error("model index moved outside write-back");

  a_result_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wb |=> (out_valid_q && (out_q.model_index == cur_q) &&
                  (out_q.accepted ? (cur_q == out_q.proposed_model)
                                  : (cur_q == $past(cur_q)))))
    else $error("result disagrees with the model index");

endmodule

// ===== design/metropolis_model_switch_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// metropolis_model_switch_step: metropolis-hastings model switch
// proposes a move of one model up or down and accepts it against
// exp(-action_delta) weighted by the transition ratio
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid_i / in_ready_o with in_data_i (step_rand,
//   accept_rand, action_delta); one transaction gives exactly one result
//   out channel: out_valid_o / out_ready_i with out_data_o (accepted,
//   proposed_model, model_index)
//   config: cfg_we_i writes model_count from cfg_wdata_i;
//   write only while no transaction is in flight
//   sequence: six ln2 reduction steps, then twelve taylor terms of three
//   steps each (term multiply, reciprocal multiply, fix) on one multiplier,
//   then the finish and the write-back; when the exponential is constant
//   (delta above 16 or below -6) or the index lies outside the model count,
//   the reduction and taylor steps are skipped
//   a new transaction is accepted only once the last one is written back
//   reset: model index 0, model_count 2, output register empty
//   stall: the output register holds a result until taken; the next
//   transaction is accepted meanwhile and waits at write-back
// ----------------------------------------------------------------------------
module metropolis_model_switch_step (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  msw_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output msw_pkg::out_t             out_data_o,
  input  logic                      cfg_we_i,
  input  logic [msw_pkg::CNT_W-1:0] cfg_wdata_i
);

  // command and status between sequencer and datapath
  msw_pkg::cmd_t cmd;
  msw_pkg::sts_t sts;

  msw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath also owns the model count register and the output register
  msw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: model switch step
// drives proposal transactions through the valid/ready input channel and
// checks every result against an in-bench predictor of the up/down proposal,
// the fixed-point exp(-delta) weight and the accept test; the model count
// is changed between phases, including out-of-range settings
// ----------------------------------------------------------------------------
module testbench;

  typedef logic [63:0] u64_t;

  // predictor plus queue of results still owed by the block
  class switch_scoreboard;
    msw_pkg::out_t             expected_moves[$];
    logic [msw_pkg::CNT_W-1:0] model_count;
    logic [msw_pkg::IDX_W-1:0] cur_model;
    int                        mismatches;

    function new();
      model_count = 5'd2;
      cur_model   = '0;
      mismatches  = 0;
    endfunction

    function void set_count(logic [msw_pkg::CNT_W-1:0] v);
      model_count = v;
    endfunction

    // exp(-delta) as unsigned q8.24, taylor series after ln2 reduction
    function u64_t boltzmann_weight(logic signed [msw_pkg::DELTA_W-1:0] delta);
      logic signed [63:0] x_q32;
      u64_t               shifted, octaves, frac, term, series, scaled;
      if (delta > msw_pkg::DELTA_HI) return '0;
      if (delta < msw_pkg::DELTA_LO) return u64_t'(msw_pkg::E_MAX);
      x_q32   = -(64'(delta)) * 65536;
      shifted = u64_t'(x_q32) + u64_t'(msw_pkg::LN2_Q32) * 24;
      octaves = shifted / u64_t'(msw_pkg::LN2_Q32);
      frac    = shifted - octaves * u64_t'(msw_pkg::LN2_Q32);
      term    = u64_t'(1) << 32;
      series  = term;
      for (int k = 1; k <= msw_pkg::EXP_TERMS; k++) begin
        term   = ((term * frac) >> 32) / u64_t'(k);
        series = series + term;
      end
      if (octaves > 32) octaves = 32;
      scaled = series >> (32 - octaves);
      if (scaled > u64_t'(msw_pkg::E_MAX)) scaled = u64_t'(msw_pkg::E_MAX);
      return scaled;
    endfunction

    function msw_pkg::out_t predict_switch(msw_pkg::in_t it);
      msw_pkg::out_t res;
      int            n, i, j, num, den;
      bit            up, acc;
      u64_t          lhs, rhs;
      n = model_count;
      if (n < msw_pkg::MIN_MODELS) n = msw_pkg::MIN_MODELS;
      if (n > msw_pkg::MAX_MODELS) n = msw_pkg::MAX_MODELS;
      i   = cur_model;
      up  = (u64_t'(it.step_rand) * u64_t'(n - 1)) >= (u64_t'(i) << msw_pkg::RAND_BITS);
      j   = up ? i + 1 : i - 1;
      acc = 1'b0;
      // an index left at or above a lowered count is always rejected
      if (i < n) begin
        if (up) begin
          num = n - 1 - i;
          den = i + 1;
        end else begin
          num = i;
          den = n - i;
        end
        lhs = (u64_t'(it.accept_rand) * u64_t'(num)) << msw_pkg::CMP_SHIFT;
        rhs = boltzmann_weight(it.action_delta) * u64_t'(den);
        acc = lhs <= rhs;
      end
      if (acc) cur_model = j[msw_pkg::IDX_W-1:0];
      res.accepted       = acc;
      res.proposed_model = j[msw_pkg::IDX_W-1:0];
      res.model_index    = cur_model;
      return res;
    endfunction

    function void note_input(msw_pkg::in_t it);
      expected_moves.push_back(predict_switch(it));
    endfunction

    function void check_result(msw_pkg::out_t got);
      msw_pkg::out_t want;
      if (expected_moves.size() == 0) begin
        $display("%0t: result with none expected: accepted %0d proposed %0d index %0d",
                 $time, got.accepted, got.proposed_model, got.model_index);
        mismatches++;
        return;
      end
      want = expected_moves.pop_front();
      if (got.accepted !== want.accepted) begin
        $display("%0t: accepted expected %0d actual %0d",
                 $time, want.accepted, got.accepted);
        mismatches++;
      end
      if (got.proposed_model !== want.proposed_model) begin
        $display("%0t: proposed_model expected %0d actual %0d",
                 $time, want.proposed_model, got.proposed_model);
        mismatches++;
      end
      if (got.model_index !== want.model_index) begin
        $display("%0t: model_index expected %0d actual %0d",
                 $time, want.model_index, got.model_index);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_moves.size();
    endfunction
  endclass

  localparam int QUIET_LIMIT  = 4000;  // cycles without any transaction
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 55;
  localparam int CALM_PHASE   = 4;     // no idling on either side here
  localparam int TAIL_CYCLES  = 60;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  msw_pkg::in_t              in_data_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  msw_pkg::out_t             out_data_o;
  logic                      cfg_we_i    = 1'b0;
  logic [msw_pkg::CNT_W-1:0] cfg_wdata_i = '0;

  switch_scoreboard sb = new();
  bit               calm = 1'b0;
  int               quiet_cycles = 0;

  // count settings of the random phases: extremes, saturating values, mid
  logic [msw_pkg::CNT_W-1:0] count_plan [PHASES] = '{5'd16, 5'd31, 5'd0, 5'd7,
                                                     5'd16, 5'd1, 5'd17, 5'd3,
                                                     5'd12, 5'd2};

  metropolis_model_switch_step i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // roughly one cycle in five idles, except during the calm phase
  function automatic bit idle_draw();
    return !calm && ($urandom_range(0, 99) < 20);
  endfunction

  // receiver stalls at random; ready changes on the falling edge only
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i = !idle_draw();
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // count cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog: block stuck or lost a result
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  function automatic msw_pkg::in_t make_move(
    logic [msw_pkg::RAND_BITS-1:0]      step,
    logic [msw_pkg::RAND_BITS-1:0]      accept,
    logic signed [msw_pkg::DELTA_W-1:0] delta);
    msw_pkg::in_t it;
    it.step_rand    = step;
    it.accept_rand  = accept;
    it.action_delta = delta;
    return it;
  endfunction

  // q0.16 random with the end values drawn now and then
  function automatic logic [msw_pkg::RAND_BITS-1:0] random_fraction();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 16) return '1;
    return msw_pkg::RAND_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic msw_pkg::in_t random_move();
    msw_pkg::in_t it;
    int           pick, d;
    it.step_rand   = random_fraction();
    it.accept_rand = random_fraction();
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // -3.0 .. 6.0: where the weight and the random are of one size
      d = int'($urandom_range(0, 9 * 65536)) - 3 * 65536;
    end else if (pick < 75) begin
      d = int'(msw_pkg::DELTA_W'($urandom()));
      d = (d << 8) >>> 8;
    end else if (pick < 90) begin
      case ($urandom_range(0, 6))
        0:       d = int'(msw_pkg::DELTA_HI);
        1:       d = int'(msw_pkg::DELTA_HI) + 1;
        2:       d = int'(msw_pkg::DELTA_LO);
        3:       d = int'(msw_pkg::DELTA_LO) - 1;
        4:       d = -8388608;
        5:       d = 8388607;
        default: d = 0;
      endcase
    end else begin
      // near either end of the computed range
      d = ($urandom_range(0, 1) ? int'(msw_pkg::DELTA_HI) : int'(msw_pkg::DELTA_LO))
          + int'($urandom_range(0, 1024)) - 512;
    end
    it.action_delta = d[msw_pkg::DELTA_W-1:0];
    return it;
  endfunction

  // present one transaction from a falling edge, hold it until taken
  task automatic send_move(msw_pkg::in_t it);
    while (idle_draw()) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(it);
    @(negedge clk_i);
  endtask

  // wait for all owed results, leaving the block idle for a register write
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_count(logic [msw_pkg::CNT_W-1:0] v);
    cfg_wdata_i = v;
    cfg_we_i    = 1'b1;
    @(posedge clk_i);
    sb.set_count(v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset count of two: field extremes and the exponential boundaries
    send_move(make_move(16'h0000, 16'h0000, 24'sd0));
    send_move(make_move(16'hFFFF, 16'hFFFF, 24'sd8388607));
    // huge delta: weight zero, only a zero accept random passes
    send_move(make_move(16'h0000, 16'h0000, 24'sd8388607));
    send_move(make_move(16'hFFFF, 16'hFFFF, -24'sd8388608));
    send_move(make_move(16'h8000, 16'h8000, msw_pkg::DELTA_HI));
    send_move(make_move(16'h7FFF, 16'h0001, msw_pkg::DELTA_HI + 24'sd1));
    send_move(make_move(16'h5555, 16'hFFFF, msw_pkg::DELTA_LO));
    send_move(make_move(16'hAAAA, 16'h0000, msw_pkg::DELTA_LO - 24'sd1));
    drain();

    // count above range saturates to sixteen; climb with certain accepts
    write_count(5'd31);
    repeat (6) send_move(make_move(16'hFFFF, 16'h0000, -24'sd8388608));
    drain();

    // lowered count leaves the index above it: proposals rejected
    write_count(5'd3);
    send_move(make_move(16'h0000, 16'h0000, -24'sd8388608));
    send_move(make_move(16'hFFFF, 16'h0000, 24'sd0));
    send_move(make_move(16'h1234, 16'hFFFF, 24'sd65536));
    drain();

    // count below range saturates to two
    write_count(5'd0);
    send_move(make_move(16'hFFFF, 16'h0000, 24'sd0));
    send_move(make_move(16'h0000, 16'h0000, -24'sd8388608));
    drain();

    // random phases, one count setting each
    for (int p = 0; p < PHASES; p++) begin
      calm = (p == CALM_PHASE);
      write_count((p == PHASES - 1) ? msw_pkg::CNT_W'($urandom_range(0, 31))
                                    : count_plan[p]);
      repeat (PHASE_ITEMS) send_move(random_move());
      drain();
    end
    calm = 1'b0;

    // give a stray extra result time to show up
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
